// ===== sv/pitw_pkg.sv =====
// ----------------------------------------------------------------------------
// pitw_pkg
// Shared types and constants for the point-in-triangle winding test.
// ----------------------------------------------------------------------------
package pitw_pkg;

  // Quadrant code of a vertex around the test point.
  typedef logic [1:0] quad_t;

  localparam quad_t QUAD_UR = 2'd0;  // right and above
  localparam quad_t QUAD_UL = 2'd1;  // left or on, above
  localparam quad_t QUAD_LL = 2'd2;  // left or on, below or on
  localparam quad_t QUAD_LR = 2'd3;  // right, below or on

  // Quadrant change along one edge, three-bit two's complement.
  typedef logic signed [2:0] dquad_t;

  localparam dquad_t DQ_POS3 = 3'sd3;
  localparam dquad_t DQ_NEG3 = -3'sd3;
  localparam dquad_t DQ_POS2 = 3'sd2;
  localparam dquad_t DQ_NEG2 = -3'sd2;
  localparam dquad_t DQ_POS1 = 3'sd1;
  localparam dquad_t DQ_NEG1 = -3'sd1;

  // Winding sum width.
  localparam int SUM_W = 4;

  // Quadrant from the two strict comparisons against the test point.
  function automatic quad_t quad_of(input logic right, input logic above);
    quad_t q;
    if (right) begin
      q = above ? QUAD_UR : QUAD_LR;
    end else begin
      q = above ? QUAD_UL : QUAD_LL;
    end
    return q;
  endfunction

endpackage

// ===== sv/pitw_front.sv =====
// ----------------------------------------------------------------------------
// pitw_front
// First stage: vertex quadrants, quadrant changes, edge differences and vertex offsets.
// ----------------------------------------------------------------------------
module pitw_front #(
  parameter int B = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [B-1:0]        test_x,
  input  logic [B-1:0]        test_y,
  input  logic [2:0][B-1:0]   vx,
  input  logic [2:0][B-1:0]   vy,
  output logic                valid,
  output logic [2:0][B-1:0]   num_mag,
  output logic [2:0][B-1:0]   den_mag,
  output logic [2:0]          qneg,
  output logic [2:0][B:0]     ofs_y,
  output logic [2:0][B:0]     ofs_x,
  output logic [2:0][2:0]     dq
);
  import pitw_pkg::*;

  quad_t            quad [3];
  logic [2:0][B:0]  num_c;
  logic [2:0][B:0]  den_c;
  logic [2:0][B:0]  ofs_y_c;
  logic [2:0][B:0]  ofs_x_c;
  logic [2:0][B-1:0] num_mag_c;
  logic [2:0][B-1:0] den_mag_c;
  logic [2:0]       qneg_c;
  logic [2:0][2:0]  dq_c;

  // Quadrant of each vertex.
  for (genvar v = 0; v < 3; v++) begin : g_quad
    assign quad[v] = quad_of($signed(vx[v]) > $signed(test_x),
                             $signed(vy[v]) > $signed(test_y));
  end

  // Per edge: current vertex e, next vertex (e + 1) mod 3.
  for (genvar e = 0; e < 3; e++) begin : g_edge
    localparam int N = (e + 1) % 3;
    always_comb begin
      num_c[e]   = {vx[e][B-1], vx[e]} - {vx[N][B-1], vx[N]};
      den_c[e]   = {vy[e][B-1], vy[e]} - {vy[N][B-1], vy[N]};
      ofs_y_c[e] = {vy[N][B-1], vy[N]} - {test_y[B-1], test_y};
      ofs_x_c[e] = {vx[N][B-1], vx[N]} - {test_x[B-1], test_x};
      num_mag_c[e] = num_c[e][B] ? B'(-num_c[e]) : num_c[e][B-1:0];
      den_mag_c[e] = den_c[e][B] ? B'(-den_c[e]) : den_c[e][B-1:0];
      qneg_c[e]  = num_c[e][B] ^ den_c[e][B];
      dq_c[e]    = {1'b0, quad[N]} - {1'b0, quad[e]};
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    num_mag <= num_mag_c;
    den_mag <= den_mag_c;
    qneg    <= qneg_c;
    ofs_y   <= ofs_y_c;
    ofs_x   <= ofs_x_c;
    dq      <= dq_c;
  end

endmodule

// ===== sv/pitw_div.sv =====
// ----------------------------------------------------------------------------
// pitw_div
// Pipelined unsigned restoring divider, one quotient bit per stage, with a
// tag that travels alongside each item.
// ----------------------------------------------------------------------------
module pitw_div #(
  parameter int B     = 16,
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic [B-1:0]     num,
  input  logic [B-1:0]     den,
  input  logic [TAG_W-1:0] tag_in,
  output logic [B-1:0]     quo,
  output logic [TAG_W-1:0] tag_out
);

  logic [B-1:0]     num_s [B+1];
  logic [B-1:0]     den_s [B+1];
  logic [B-1:0]     rem_s [B+1];
  logic [B-1:0]     quo_s [B+1];
  logic [TAG_W-1:0] tag_s [B+1];

  assign num_s[0] = num;
  assign den_s[0] = den;
  assign rem_s[0] = '0;
  assign quo_s[0] = '0;
  assign tag_s[0] = tag_in;

  // One stage per quotient bit, most significant bit first.
  for (genvar k = 0; k < B; k++) begin : g_stage
    logic [B:0] trial;
    logic       ge;
    logic [B:0] diff;

    always_comb begin
      trial = {rem_s[k], num_s[k][B-1]};
      ge    = trial >= {1'b0, den_s[k]};
      diff  = trial - {1'b0, den_s[k]};
    end

    always_ff @(posedge clk) begin
      rem_s[k+1] <= ge ? diff[B-1:0] : trial[B-1:0];
      quo_s[k+1] <= {quo_s[k][B-2:0], ge};
      num_s[k+1] <= {num_s[k][B-2:0], 1'b0};
      den_s[k+1] <= den_s[k];
      tag_s[k+1] <= tag_s[k];
    end
  end

  assign quo     = quo_s[B];
  assign tag_out = tag_s[B];

endmodule

// ===== sv/pitw_back.sv =====
// ----------------------------------------------------------------------------
// pitw_back
// Back end: signed quotient, intercept product, side test and winding sum.
// ----------------------------------------------------------------------------
module pitw_back #(
  parameter int B = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [2:0][B-1:0]      qmag,
  input  logic [2:0]             qneg,
  input  logic [2:0][B:0]        ofs_y,
  input  logic [2:0][B:0]        ofs_x,
  input  logic [2:0][2:0]        dq,
  output logic                   done,
  output logic                   inside_res,
  output logic [pitw_pkg::SUM_W-1:0] winding_sum
);
  import pitw_pkg::*;

  localparam int PW = 2 * B + 2;

  // Stage one: apply the quotient sign.
  logic             nv;
  logic [2:0][B:0]  q_n;
  logic [2:0][B:0]  ofs_y_n;
  logic [2:0][B:0]  ofs_x_n;
  logic [2:0][2:0]  dq_n;

  // Stage two: intercept product.
  logic              pv;
  logic [2:0][PW-1:0] prod_p;
  logic [2:0][B:0]   ofs_x_p;
  logic [2:0][2:0]   dq_p;

  // Stage three: side test and sum.
  logic [2:0]       right;
  dquad_t           adj [3];
  logic [SUM_W-1:0] sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      nv   <= 1'b0;
      pv   <= 1'b0;
      done <= 1'b0;
    end else begin
      nv   <= in_valid;
      pv   <= nv;
      done <= pv;
    end
  end

  for (genvar e = 0; e < 3; e++) begin : g_edge
    always_ff @(posedge clk) begin
      q_n[e]     <= qneg[e] ? (B+1)'(-{1'b0, qmag[e]}) : {1'b0, qmag[e]};
      ofs_y_n[e] <= ofs_y[e];
      ofs_x_n[e] <= ofs_x[e];
      dq_n[e]    <= dq[e];
    end

    always_ff @(posedge clk) begin
      prod_p[e]  <= $signed(ofs_y_n[e]) * $signed(q_n[e]);
      ofs_x_p[e] <= ofs_x_n[e];
      dq_p[e]    <= dq_n[e];
    end

    // The intercept lies right of the test point when the x offset of the
    // next vertex exceeds the scaled y offset.
    always_comb begin
      right[e] = $signed({{(PW-B-1){ofs_x_p[e][B]}}, ofs_x_p[e]}) > $signed(prod_p[e]);
      priority if (dquad_t'(dq_p[e]) == DQ_POS3) begin
        adj[e] = DQ_NEG1;
      end else if (dquad_t'(dq_p[e]) == DQ_NEG3) begin
        adj[e] = DQ_POS1;
      end else if (dquad_t'(dq_p[e]) == DQ_POS2 || dquad_t'(dq_p[e]) == DQ_NEG2) begin
        adj[e] = right[e] ? dquad_t'(-dq_p[e]) : dquad_t'(dq_p[e]);
      end else begin
        adj[e] = dquad_t'(dq_p[e]);
      end
    end
  end

  // Sum the three adjusted changes.
  always_comb begin
    sum_next = SUM_W'(adj[0]) + SUM_W'(adj[1]) + SUM_W'(adj[2]);
  end

  always_ff @(posedge clk) begin
    winding_sum <= sum_next;
    inside_res  <= sum_next[2];
  end

endmodule

// ===== sv/point_in_triangle_winding.sv =====
// ----------------------------------------------------------------------------
// point_in_triangle_winding
// Point-in-triangle test by quadrant winding over the three closed edges.
// ----------------------------------------------------------------------------
// A new item is taken in every cycle that start is high; busy is always low.
// Each item's result is accepted with done, in order, one result per item.
// On its way it passes through a front stage, the intercept quotient,
// which is computed one bit per pipeline stage, a sign stage, a multiply
// stage and the output register.
// Results are not held: the receiver must take each one in its done cycle.
module point_in_triangle_winding #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] test_x,
  input  logic [COORD_BITS-1:0] test_y,
  input  logic [COORD_BITS-1:0] v0_x,
  input  logic [COORD_BITS-1:0] v0_y,
  input  logic [COORD_BITS-1:0] v1_x,
  input  logic [COORD_BITS-1:0] v1_y,
  input  logic [COORD_BITS-1:0] v2_x,
  input  logic [COORD_BITS-1:0] v2_y,
  output logic                  done,
  output logic                  inside_res,
  output logic [pitw_pkg::SUM_W-1:0] winding_sum
);
  import pitw_pkg::*;

  localparam int B     = COORD_BITS;
  localparam int TAG_W = 3 + 1 + 2 * (B + 1);
  localparam int LAT   = B + 4;

  logic [2:0][B-1:0] vx;
  logic [2:0][B-1:0] vy;
  logic              f_valid;
  logic [2:0][B-1:0] num_mag;
  logic [2:0][B-1:0] den_mag;
  logic [2:0]        f_qneg;
  logic [2:0][B:0]   f_ofs_y;
  logic [2:0][B:0]   f_ofs_x;
  logic [2:0][2:0]   f_dq;

  logic [B-1:0]      dv;
  logic [2:0][B-1:0] qmag;
  logic [2:0]        d_qneg;
  logic [2:0][B:0]   d_ofs_y;
  logic [2:0][B:0]   d_ofs_x;
  logic [2:0][2:0]   d_dq;

  // The pipeline never stalls.
  assign busy = 1'b0;

  assign vx = {v2_x, v1_x, v0_x};
  assign vy = {v2_y, v1_y, v0_y};

  pitw_front #(.B(B)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start),
    .test_x   (test_x),
    .test_y   (test_y),
    .vx       (vx),
    .vy       (vy),
    .valid    (f_valid),
    .num_mag  (num_mag),
    .den_mag  (den_mag),
    .qneg     (f_qneg),
    .ofs_y    (f_ofs_y),
    .ofs_x    (f_ofs_x),
    .dq       (f_dq)
  );

  // One divider per edge; the edge's other values ride along as its tag.
  for (genvar e = 0; e < 3; e++) begin : g_div
    logic [TAG_W-1:0] tag_in;
    logic [TAG_W-1:0] tag_out;

    assign tag_in = {f_dq[e], f_qneg[e], f_ofs_y[e], f_ofs_x[e]};

    pitw_div #(.B(B), .TAG_W(TAG_W)) u_div (
      .clk     (clk),
      .num     (num_mag[e]),
      .den     (den_mag[e]),
      .tag_in  (tag_in),
      .quo     (qmag[e]),
      .tag_out (tag_out)
    );

    assign d_ofs_x[e] = tag_out[B:0];
    assign d_ofs_y[e] = tag_out[2*B+1:B+1];
    assign d_qneg[e]  = tag_out[2*B+2];
    assign d_dq[e]    = tag_out[TAG_W-1:2*B+3];
  end

  // Valid bits alongside the divider stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= '0;
    end else begin
      dv <= {dv[B-2:0], f_valid};
    end
  end

  pitw_back #(.B(B)) u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (dv[B-1]),
    .qmag        (qmag),
    .qneg        (d_qneg),
    .ofs_y       (d_ofs_y),
    .ofs_x       (d_ofs_x),
    .dq          (d_dq),
    .done        (done),
    .inside_res  (inside_res),
    .winding_sum (winding_sum)
  );

`ifndef SYNTH
  // Every result traces back to an item taken a fixed latency earlier.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without a matching item");

  // A closed loop of quadrant changes always sums to a multiple of four.
  a_sum_mod4: assert property (@(posedge clk) disable iff (rst)
    done |-> (winding_sum[1:0] == 2'b00))
    else $error("winding sum is not a multiple of four");

  // The sum never leaves its range.
  a_sum_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ($signed(winding_sum) >= -4'sd6 && $signed(winding_sum) <= 4'sd6))
    else $error("winding sum out of range");
`endif

endmodule
